@@ hdl/smcpp_pkg.sv @@
// Shared types, codes and constants for the serial memory card and pad port.
// No dependencies; imported by the controller, datapath and top level.
package smcpp_pkg;

  localparam int SECTOR_BYTES_DEF = 128;
  localparam int SECTOR_COUNT_DEF = 1024;
  localparam int FIFO_DEPTH_DEF   = 8;

  // item kinds
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_PAD   = 2'd2;

  // register offsets
  localparam logic [3:0] REG_DATA = 4'd0;
  localparam logic [3:0] REG_STAT = 4'd4;
  localparam logic [3:0] REG_MODE = 4'd8;
  localparam logic [3:0] REG_CTRL = 4'd10;
  localparam logic [3:0] REG_BAUD = 4'd14;

  // link bytes
  localparam logic [7:0] SEL_CARD  = 8'h81;
  localparam logic [7:0] SEL_PAD   = 8'h01;
  localparam logic [7:0] CMD_READ  = 8'h52;
  localparam logic [7:0] CMD_WRITE = 8'h57;
  localparam logic [7:0] CMD_ID    = 8'h53;
  localparam logic [7:0] ACK_A     = 8'h5A;
  localparam logic [7:0] ACK_B     = 8'h5D;
  localparam logic [7:0] ACK_C     = 8'h5C;
  localparam logic [7:0] END_GOOD  = 8'h47;
  localparam logic [7:0] END_BAD   = 8'h4E;
  localparam logic [7:0] CMD_POLL  = 8'h42;
  localparam logic [7:0] PAD_ID    = 8'h41;
  localparam logic [7:0] NO_REPLY  = 8'hFF;

  localparam logic [15:0] STATUS_RST = 16'h0005;
  localparam logic [15:0] MODE_RST   = 16'h000D;
  localparam logic [15:0] BAUD_RST   = 16'h0088;
  localparam logic [15:0] PAD_RST    = 16'hFFFF;
  localparam logic [7:0]  FLAG_RST   = 8'h08;

  typedef enum logic [5:0] {
    P_IDLE, P_WAIT_CMD,
    P_RD_ID1, P_RD_ID2, P_RD_MSB, P_RD_LSB, P_RD_ACK2,
    P_RD_CONF_MSB, P_RD_CONF_LSB, P_RD_DATA, P_RD_CHK, P_RD_END,
    P_WR_ID1, P_WR_ID2, P_WR_MSB, P_WR_LSB, P_WR_DATA, P_WR_CHK,
    P_WR_ACK2, P_WR_END,
    P_ID_1, P_ID_2, P_ID_3, P_ID_4, P_ID_5, P_ID_6, P_ID_7, P_ID_8,
    P_PAD_POLL, P_PAD_B1, P_PAD_LO, P_PAD_HI
  } proto_t;

  typedef enum logic [2:0] {
    C_CLEAR, C_IDLE, C_EXEC, C_COMMIT, C_OUT
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic clear;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic commit_req;
    logic commit_done;
  } stat_t;

  function automatic logic [7:0] id_reply(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h5A;
      3'd1:    b = 8'h5D;
      3'd2:    b = 8'h5C;
      3'd3:    b = 8'h5D;
      3'd4:    b = 8'h04;
      3'd7:    b = 8'h80;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ hdl/smcpp_ctrl.sv @@
// Sequencer for the port: clearing pass, accept, execute, commit, result.
// Depends on smcpp_pkg.
module smcpp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  smcpp_pkg::stat_t    stat,
  output smcpp_pkg::cmd_t     cmd
);
  import smcpp_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= C_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      C_CLEAR:  if (stat.clear_done) state_nxt = C_IDLE;
      C_IDLE:   if (in_tvalid) state_nxt = C_EXEC;
      C_EXEC:   state_nxt = stat.commit_req ? C_COMMIT : C_OUT;
      C_COMMIT: if (stat.commit_done) state_nxt = C_OUT;
      C_OUT:    if (out_tready) state_nxt = C_IDLE;
      default:  state_nxt = C_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.capture = (state_r == C_IDLE) && in_tvalid;
    cmd.exec    = (state_r == C_EXEC);
    cmd.clear   = (state_r == C_CLEAR);
    cmd.commit  = (state_r == C_COMMIT);
    in_tready   = (state_r == C_IDLE);
    out_tvalid  = (state_r == C_OUT);
  end

`ifndef NO_ASSERTIONS
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("ready and valid together");
  a_cap_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == C_EXEC) else $error("capture not followed by exec");
  a_commit_src: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == C_COMMIT) |-> ($past(state_r) == C_EXEC || $past(state_r) == C_COMMIT))
    else $error("commit entered out of order");
`endif

endmodule

@@ hdl/smcpp_dpath.sv @@
// Datapath: registers, receive FIFO, protocol machine, card store and write buffer.
// Depends on smcpp_pkg; driven by smcpp_ctrl commands.
module smcpp_dpath #(
  parameter int SECTOR_BYTES = smcpp_pkg::SECTOR_BYTES_DEF,
  parameter int SECTOR_COUNT = smcpp_pkg::SECTOR_COUNT_DEF,
  parameter int FIFO_DEPTH   = smcpp_pkg::FIFO_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  smcpp_pkg::cmd_t  cmd,
  output smcpp_pkg::stat_t stat,
  input  logic [1:0]       op,
  input  logic [3:0]       reg_offset,
  input  logic [15:0]      write_data,
  output logic [15:0]      read_data,
  output logic             irq_pending
);
  import smcpp_pkg::*;

  localparam int CARD_BYTES = SECTOR_BYTES * SECTOR_COUNT;
  localparam int CW  = $clog2(CARD_BYTES);
  localparam int SW  = $clog2(SECTOR_COUNT);
  localparam int BIW = $clog2(SECTOR_BYTES);
  localparam int BCW = $clog2(SECTOR_BYTES + 1);
  localparam int PW  = $clog2(FIFO_DEPTH);
  localparam int FW  = $clog2(FIFO_DEPTH + 1);

  // captured item
  logic [1:0]  op_r;
  logic [3:0]  off_r;
  logic [15:0] wd_r;

  proto_t      pst_r, pst_nxt;
  logic [7:0]  sec_hi_r, sec_hi_nxt, sec_lo_r, sec_lo_nxt;
  logic [BCW-1:0] bc_r, bc_nxt;
  logic [7:0]  chk_r, chk_nxt;
  logic        ok_r, ok_nxt;
  logic [7:0]  flag_r, flag_nxt;
  logic [15:0] status_r, status_nxt, mode_r, mode_nxt, ctrl_r, ctrl_nxt;
  logic [15:0] baud_r, baud_nxt, pad_r, pad_nxt;
  logic [15:0] rd_r, rd_nxt;

  logic [7:0]    q_r [FIFO_DEPTH];
  logic [PW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          q_we;
  logic [7:0]    put_byte;

  logic [7:0] card [CARD_BYTES];
  logic [7:0] wbuf [SECTOR_BYTES];
  logic [7:0] card_rdata_r, wb_rdata_r;
  logic       wb_we;

  logic [CW-1:0]  clr_addr_r;
  logic [BIW-1:0] clr_byte_r;
  logic [SW-1:0]  clr_sec_r;
  logic [BCW-1:0] cm_r;

  logic [15:0]    sec16;
  logic           in_range;
  logic [CW-1:0]  base, rd_addr, mem_waddr;
  logic [BIW-1:0] bc_idx, wb_raddr;
  logic [7:0]     mem_wdata, fmt;
  logic           mem_we;
  logic [7:0]     tx;

  assign sec16    = {sec_hi_r, sec_lo_r};
  assign in_range = {1'b0, sec16} < 17'(SECTOR_COUNT);
  assign base     = CW'(sec16[SW-1:0]) * CW'(SECTOR_BYTES);
  assign bc_idx   = (bc_r < BCW'(SECTOR_BYTES)) ? bc_r[BIW-1:0] : '0;
  assign rd_addr  = base + CW'(bc_idx);
  assign wb_raddr = (cm_r < BCW'(SECTOR_BYTES)) ? cm_r[BIW-1:0] : '0;
  assign tx       = wd_r[7:0];

  // formatted image: header frame then fifteen free directory frames
  always_comb begin
    fmt = 8'h00;
    if (clr_sec_r == '0) begin
      if (clr_byte_r == BIW'(0))                     fmt = 8'h4D;
      else if (clr_byte_r == BIW'(1))                fmt = 8'h43;
      else if (clr_byte_r == BIW'(SECTOR_BYTES - 1)) fmt = 8'h0E;
    end else if (clr_sec_r <= SW'(15)) begin
      if (clr_byte_r == BIW'(0) || clr_byte_r == BIW'(SECTOR_BYTES - 1)) fmt = 8'hA0;
      else if (clr_byte_r == BIW'(8) || clr_byte_r == BIW'(9))           fmt = 8'hFF;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_r;
    mem_wdata = fmt;
    if (cmd.clear) begin
      mem_we = 1'b1;
    end else if (cmd.commit && cm_r != '0) begin
      mem_we    = 1'b1;
      mem_waddr = base + CW'(cm_r - BCW'(1));
      mem_wdata = wb_rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) card[mem_waddr] <= mem_wdata;
    card_rdata_r <= card[rd_addr];
    if (cmd.exec && wb_we) wbuf[bc_idx] <= tx;
    wb_rdata_r <= wbuf[wb_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clr_byte_r <= '0;
      clr_sec_r  <= '0;
      cm_r       <= '0;
    end else begin
      if (cmd.clear) begin
        clr_addr_r <= clr_addr_r + CW'(1);
        if (clr_byte_r == BIW'(SECTOR_BYTES - 1)) begin
          clr_byte_r <= '0;
          clr_sec_r  <= clr_sec_r + SW'(1);
        end else begin
          clr_byte_r <= clr_byte_r + BIW'(1);
        end
      end
      if (stat.commit_done)  cm_r <= '0;
      else if (cmd.commit)   cm_r <= cm_r + BCW'(1);
    end
  end

  always_comb begin
    stat.clear_done  = cmd.clear && (clr_addr_r == CW'(CARD_BYTES - 1));
    stat.commit_done = cmd.commit && (cm_r == BCW'(SECTOR_BYTES));
    stat.commit_req  = cmd.exec && op_r == OP_WRITE && off_r == REG_DATA &&
                       pst_r == P_WR_END && ok_r && in_range;
  end

  // one item's effect
  always_comb begin
    logic       put_en;
    logic [7:0] b;
    pst_nxt    = pst_r;
    sec_hi_nxt = sec_hi_r;
    sec_lo_nxt = sec_lo_r;
    bc_nxt     = bc_r;
    chk_nxt    = chk_r;
    ok_nxt     = ok_r;
    flag_nxt   = flag_r;
    status_nxt = status_r;
    mode_nxt   = mode_r;
    ctrl_nxt   = ctrl_r;
    baud_nxt   = baud_r;
    pad_nxt    = pad_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    fill_nxt   = fill_r;
    rd_nxt     = 16'h0000;
    put_en     = 1'b0;
    put_byte   = NO_REPLY;
    q_we       = 1'b0;
    wb_we      = 1'b0;
    b          = 8'h00;

    case (op_r)
      OP_READ: begin
        case (off_r)
          REG_DATA: begin
            if (fill_r == '0) begin
              rd_nxt = 16'h00FF;
            end else begin
              rd_nxt   = {8'h00, q_r[tail_r]};
              tail_nxt = (tail_r == PW'(FIFO_DEPTH - 1)) ? '0 : tail_r + PW'(1);
              fill_nxt = fill_r - FW'(1);
              if (fill_nxt == '0) status_nxt[1] = 1'b0;
            end
          end
          REG_STAT: rd_nxt = status_r;
          REG_MODE: rd_nxt = mode_r;
          REG_CTRL: rd_nxt = ctrl_r;
          REG_BAUD: rd_nxt = baud_r;
          default:  rd_nxt = 16'h0000;
        endcase
      end
      OP_WRITE: begin
        case (off_r)
          REG_DATA: begin
            put_en = 1'b1;
            case (pst_r)
              P_WAIT_CMD: begin
                put_byte = flag_r;
                if (tx == CMD_READ)       pst_nxt = P_RD_ID1;
                else if (tx == CMD_WRITE) pst_nxt = P_WR_ID1;
                else if (tx == CMD_ID)    pst_nxt = P_ID_1;
                else begin
                  put_byte = NO_REPLY;
                  pst_nxt  = P_IDLE;
                end
              end
              P_RD_ID1: begin put_byte = ACK_A; pst_nxt = P_RD_ID2; end
              P_RD_ID2: begin put_byte = ACK_B; pst_nxt = P_RD_MSB; end
              P_RD_MSB: begin
                sec_hi_nxt = tx; put_byte = 8'h00; pst_nxt = P_RD_LSB;
              end
              P_RD_LSB: begin
                sec_lo_nxt = tx;
                chk_nxt    = sec_hi_r ^ tx;
                put_byte   = ACK_C;
                pst_nxt    = P_RD_ACK2;
              end
              P_RD_ACK2:     begin put_byte = ACK_B; pst_nxt = P_RD_CONF_MSB; end
              P_RD_CONF_MSB: begin put_byte = sec_hi_r; pst_nxt = P_RD_CONF_LSB; end
              P_RD_CONF_LSB: begin
                put_byte = sec_lo_r; bc_nxt = '0; pst_nxt = P_RD_DATA;
              end
              P_RD_DATA: begin
                if (in_range && bc_r < BCW'(SECTOR_BYTES)) b = card_rdata_r;
                put_byte = b;
                chk_nxt  = chk_r ^ b;
                bc_nxt   = bc_r + BCW'(1);
                if (bc_nxt >= BCW'(SECTOR_BYTES)) pst_nxt = P_RD_CHK;
              end
              P_RD_CHK: begin put_byte = chk_r; pst_nxt = P_RD_END; end
              P_RD_END: begin
                put_byte = END_GOOD; pst_nxt = P_IDLE; status_nxt[7] = 1'b0;
              end
              P_WR_ID1: begin put_byte = ACK_A; pst_nxt = P_WR_ID2; end
              P_WR_ID2: begin put_byte = ACK_B; pst_nxt = P_WR_MSB; end
              P_WR_MSB: begin
                sec_hi_nxt = tx; put_byte = 8'h00; pst_nxt = P_WR_LSB;
              end
              P_WR_LSB: begin
                sec_lo_nxt = tx;
                chk_nxt    = sec_hi_r ^ tx;
                bc_nxt     = '0;
                put_byte   = 8'h00;
                pst_nxt    = P_WR_DATA;
              end
              P_WR_DATA: begin
                if (bc_r < BCW'(SECTOR_BYTES)) begin
                  wb_we   = 1'b1;
                  chk_nxt = chk_r ^ tx;
                  bc_nxt  = bc_r + BCW'(1);
                end
                put_byte = 8'h00;
                if (bc_nxt >= BCW'(SECTOR_BYTES)) pst_nxt = P_WR_CHK;
              end
              P_WR_CHK: begin
                ok_nxt = (tx == chk_r); put_byte = ACK_C; pst_nxt = P_WR_ACK2;
              end
              P_WR_ACK2: begin put_byte = ACK_B; pst_nxt = P_WR_END; end
              P_WR_END: begin
                put_byte      = ok_r ? END_GOOD : END_BAD;
                flag_nxt      = 8'h00;
                pst_nxt       = P_IDLE;
                status_nxt[7] = 1'b0;
              end
              P_ID_1, P_ID_2, P_ID_3, P_ID_4, P_ID_5, P_ID_6, P_ID_7: begin
                put_byte = id_reply(3'(6'(pst_r) - 6'(P_ID_1)));
                pst_nxt  = proto_t'(6'(pst_r) + 6'd1);
              end
              P_ID_8: begin
                put_byte = id_reply(3'd7); pst_nxt = P_IDLE; status_nxt[7] = 1'b0;
              end
              P_PAD_POLL: begin
                if (tx == CMD_POLL) begin put_byte = PAD_ID; pst_nxt = P_PAD_B1; end
                else begin put_byte = NO_REPLY; pst_nxt = P_IDLE; end
              end
              P_PAD_B1: begin put_byte = ACK_A; pst_nxt = P_PAD_LO; end
              P_PAD_LO: begin put_byte = pad_r[7:0]; pst_nxt = P_PAD_HI; end
              P_PAD_HI: begin
                put_byte = pad_r[15:8]; pst_nxt = P_IDLE; status_nxt[7] = 1'b0;
              end
              default: begin
                put_byte = NO_REPLY;
                if (tx == SEL_CARD) begin
                  pst_nxt = P_WAIT_CMD; status_nxt[7] = 1'b1;
                end else if (tx == SEL_PAD) begin
                  pst_nxt = P_PAD_POLL; status_nxt[7] = 1'b1;
                end else begin
                  pst_nxt = P_IDLE;
                end
              end
            endcase
            if (put_en && fill_r < FW'(FIFO_DEPTH)) begin
              q_we          = 1'b1;
              head_nxt      = (head_r == PW'(FIFO_DEPTH - 1)) ? '0 : head_r + PW'(1);
              fill_nxt      = fill_r + FW'(1);
              status_nxt[1] = 1'b1;
            end
            if (ctrl_r[12] && status_nxt[7]) status_nxt[9] = 1'b1;
          end
          REG_MODE: mode_nxt = wd_r;
          REG_CTRL: begin
            ctrl_nxt = wd_r;
            if (wd_r[4]) status_nxt[9] = 1'b0;
            if (wd_r[6]) begin
              pst_nxt    = P_IDLE;
              head_nxt   = '0;
              tail_nxt   = '0;
              fill_nxt   = '0;
              status_nxt = STATUS_RST;
            end
          end
          REG_BAUD: baud_nxt = wd_r;
          default:  rd_nxt = 16'h0000;
        endcase
      end
      OP_PAD:  pad_nxt = wd_r;
      default: rd_nxt = 16'h0000;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= op;
      off_r <= reg_offset;
      wd_r  <= write_data;
    end
    if (cmd.exec) begin
      rd_r <= rd_nxt;
      if (q_we) q_r[head_r] <= put_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pst_r    <= P_IDLE;
      sec_hi_r <= '0;
      sec_lo_r <= '0;
      bc_r     <= '0;
      chk_r    <= '0;
      ok_r     <= 1'b0;
      flag_r   <= FLAG_RST;
      status_r <= STATUS_RST;
      mode_r   <= MODE_RST;
      ctrl_r   <= '0;
      baud_r   <= BAUD_RST;
      pad_r    <= PAD_RST;
      head_r   <= '0;
      tail_r   <= '0;
      fill_r   <= '0;
    end else if (cmd.exec) begin
      pst_r    <= pst_nxt;
      sec_hi_r <= sec_hi_nxt;
      sec_lo_r <= sec_lo_nxt;
      bc_r     <= bc_nxt;
      chk_r    <= chk_nxt;
      ok_r     <= ok_nxt;
      flag_r   <= flag_nxt;
      status_r <= status_nxt;
      mode_r   <= mode_nxt;
      ctrl_r   <= ctrl_nxt;
      baud_r   <= baud_nxt;
      pad_r    <= pad_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      fill_r   <= fill_nxt;
    end
  end

  assign read_data   = rd_r;
  assign irq_pending = status_r[9];

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(FIFO_DEPTH)) else $error("fifo overfilled");
  a_rx_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) == !status_r[1]) else $error("rx flag out of step with fill");
  a_fixed_bits: assert property (@(posedge clk) disable iff (!rst_n)
    status_r[0] && status_r[2]) else $error("fixed status bits lost");
`endif

endmodule

@@ hdl/serial_memory_card_and_pad_port.sv @@
// Serial memory card and pad port, top level.
// Each accepted beat is executed in the EXEC state and its result is then held valid in OUT
// until taken; a committed sector write passes through COMMIT first (card store write port,
// one byte a cycle). A new beat is taken only once the result of the last has been taken.
// After reset a clearing pass writes the formatted card image, one byte a cycle, before the
// first beat is taken.
module serial_memory_card_and_pad_port #(
  parameter int SECTOR_BYTES = smcpp_pkg::SECTOR_BYTES_DEF,
  parameter int SECTOR_COUNT = smcpp_pkg::SECTOR_COUNT_DEF,
  parameter int FIFO_DEPTH   = smcpp_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [3:0] reg_offset, [19:4] write_data, [23:20] zero
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [15:0] read_data, [16] irq_pending, [23:17] zero
);
  import smcpp_pkg::*;

  cmd_t        cmd;
  stat_t       stat;
  logic [15:0] read_data;
  logic        irq_pending;

  smcpp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  smcpp_dpath #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .SECTOR_COUNT (SECTOR_COUNT),
    .FIFO_DEPTH   (FIFO_DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .op          (in_tuser),
    .reg_offset  (in_tdata[3:0]),
    .write_data  (in_tdata[19:4]),
    .read_data   (read_data),
    .irq_pending (irq_pending)
  );

  assign out_tdata = {7'b0, irq_pending, read_data};

endmodule
